// ===== rtl/lcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg: shared definitions for the largest component size block
// Field widths, default table depth and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lcs_pkg;

   localparam int VERTEX_W         = 10;   // request vertex fields
   localparam int COUNT_W          = 11;   // vertex count register
   localparam int SIZE_W           = 11;   // component sizes and result
   localparam int MAX_VERTICES_DEF = 1024; // default union-find table depth

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_edge;   // capture endpoints, start walk at vertex a
      logic emit;        // load result register, clear running maximum
      logic clr_step;    // write one reset entry, advance sweep pointer
      logic rd;          // read table entry at walk pointer
      logic chk_a;       // examine read data for walk from a
      logic chk_b;       // examine read data for walk from b
      logic link_small;  // point smaller root at larger root
      logic link_big;    // store merged size at larger root
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic req_finish;  // request on the port is a finish
      logic req_edge_ok; // both endpoints below the effective count
      logic rsp_busy;    // result register holds a result not taken now
      logic clr_last;    // sweep pointer at last table entry
      logic is_root;     // read entry links to itself
      logic roots_eq;    // both walks ended at the same root
   } ctrl_status_type;

endpackage

// ===== rtl/lcs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_ctrl: sequencer for the largest component size block
// Steps the table clearing sweep, the two root walks and the two-write merge.
// ----------------------------------------------------------------------------
module lcs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  lcs_pkg::ctrl_status_type status,
   output lcs_pkg::ctrl_cmd_type    cmd
);
   import lcs_pkg::*;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_RD_A  = 8'b0000_0100,
      S_CHK_A = 8'b0000_1000,
      S_RD_B  = 8'b0001_0000,
      S_CHK_B = 8'b0010_0000,
      S_MERGE = 8'b0100_0000,
      S_LINK  = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // Requests are taken in idle only; a finish also waits when the result register cannot be freed this cycle
   assign req_ready = (state_ff == S_IDLE) && !(status.req_finish && status.rsp_busy);
   assign accept    = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (status.req_finish) begin
                  cmd.emit = 1'b1;
                  state_in = S_CLEAR;
               end else if (status.req_edge_ok) begin
                  cmd.load_edge = 1'b1;
                  state_in      = S_RD_A;
               end
            end
         end
         S_RD_A: begin
            cmd.rd   = 1'b1;
            state_in = S_CHK_A;
         end
         S_CHK_A: begin
            cmd.chk_a = 1'b1;
            state_in  = status.is_root ? S_RD_B : S_RD_A;
         end
         S_RD_B: begin
            cmd.rd   = 1'b1;
            state_in = S_CHK_B;
         end
         S_CHK_B: begin
            cmd.chk_b = 1'b1;
            state_in  = status.is_root ? S_MERGE : S_RD_B;
         end
         S_MERGE: begin
            if (status.roots_eq) begin
               state_in = S_IDLE;
            end else begin
               cmd.link_small = 1'b1;
               state_in       = S_LINK;
            end
         end
         S_LINK: begin
            cmd.link_big = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // State register; reset starts the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   // A finish always starts a clearing sweep
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> state_ff == S_CLEAR)
      else $error("finish not followed by clearing sweep");

   // The sweep ends after the last entry
   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) && status.clr_last |=> state_ff == S_IDLE)
      else $error("clearing sweep overran");

   // A merge is always the two writes back to back
   a_link_pair: assert property (@(posedge clock) disable iff (reset)
      cmd.link_small |=> cmd.link_big)
      else $error("merge missing second write");

   // No finish is taken while an untaken result would be overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !status.rsp_busy)
      else $error("result overwritten before taken");
`endif

endmodule

// ===== rtl/lcs_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_dpath: union-find table and registers for the largest component size
// One table memory holds parent link and size per vertex; walk pointer,
// roots, running maximum, vertex count and result register.
// ----------------------------------------------------------------------------
module lcs_dpath #(
   parameter int MAX_VERTICES = lcs_pkg::MAX_VERTICES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_cmd,
   input  logic [lcs_pkg::VERTEX_W-1:0]    req_vertex_a,
   input  logic [lcs_pkg::VERTEX_W-1:0]    req_vertex_b,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [lcs_pkg::SIZE_W-1:0]      rsp_largest_size,
   input  logic                            csr_wr_en,
   input  logic [lcs_pkg::COUNT_W-1:0]     csr_wr_data,
   input  lcs_pkg::ctrl_cmd_type           cmd,
   output lcs_pkg::ctrl_status_type        status
);
   import lcs_pkg::*;

   localparam int VW = $clog2(MAX_VERTICES);

   typedef struct packed {
      logic [VW-1:0]     parent;
      logic [SIZE_W-1:0] size;
   } entry_type;

   entry_type             mem [MAX_VERTICES];
   entry_type             rd_data_ff;
   entry_type             wr_data;
   logic [VW-1:0]         wr_addr;
   logic                  wr_en;

   logic [COUNT_W-1:0]    vcount_ff;
   logic [VW-1:0]         clr_idx_ff;
   logic [VW-1:0]         cur_ff;
   logic [VW-1:0]         cur_in;
   logic [VW-1:0]         vb_ff;
   logic [VW-1:0]         root_a_ff;
   logic [VW-1:0]         root_b_ff;
   logic [SIZE_W-1:0]     size_a_ff;
   logic [SIZE_W-1:0]     size_b_ff;
   logic [SIZE_W-1:0]     largest_ff;
   logic                  rsp_valid_ff;
   logic [SIZE_W-1:0]     rsp_largest_size_ff;

   logic                  a_ok;
   logic                  b_ok;
   logic                  a_swap;
   logic [VW-1:0]         big_root;
   logic [VW-1:0]         small_root;
   logic [SIZE_W-1:0]     small_size;
   logic [SIZE_W-1:0]     merged;
   logic [SIZE_W-1:0]     result;

   // Range check against the count in force and the table depth
   assign a_ok = ({1'b0, req_vertex_a} < vcount_ff) && (32'(req_vertex_a) < MAX_VERTICES);
   assign b_ok = ({1'b0, req_vertex_b} < vcount_ff) && (32'(req_vertex_b) < MAX_VERTICES);

   // Union by size: the smaller root links under the larger
   assign a_swap     = size_a_ff < size_b_ff;
   assign big_root   = a_swap ? root_b_ff : root_a_ff;
   assign small_root = a_swap ? root_a_ff : root_b_ff;
   assign small_size = a_swap ? size_a_ff : size_b_ff;
   assign merged     = size_a_ff + size_b_ff;

   // Empty graph gives 0; otherwise at least one vertex
   always_comb begin
      if (vcount_ff == '0) begin
         result = '0;
      end else if (largest_ff > SIZE_W'(1)) begin
         result = largest_ff;
      end else begin
         result = SIZE_W'(1);
      end
   end

   // Status to controller
   assign status.req_finish  = req_cmd;
   assign status.req_edge_ok = a_ok && b_ok;
   assign status.rsp_busy    = rsp_valid_ff && !rsp_ready;
   assign status.clr_last    = clr_idx_ff == VW'(MAX_VERTICES - 1);
   assign status.is_root     = rd_data_ff.parent == cur_ff;
   assign status.roots_eq    = root_a_ff == root_b_ff;

   // Table write port: sweep, link of small root, size of big root
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_idx_ff;
      wr_data = '{parent: clr_idx_ff, size: SIZE_W'(1)};
      if (cmd.clr_step) begin
         wr_en = 1'b1;
      end else if (cmd.link_small) begin
         wr_en   = 1'b1;
         wr_addr = small_root;
         wr_data = '{parent: big_root, size: small_size};
      end else if (cmd.link_big) begin
         wr_en   = 1'b1;
         wr_addr = big_root;
         wr_data = '{parent: big_root, size: merged};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Table read port, registered
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_data_ff <= mem[cur_ff];
      end
   end

   // Walk pointer
   always_comb begin
      cur_in = cur_ff;
      if (cmd.load_edge) begin
         cur_in = VW'(req_vertex_a);
      end else if (cmd.chk_a && status.is_root) begin
         cur_in = vb_ff;
      end else if ((cmd.chk_a || cmd.chk_b) && !status.is_root) begin
         cur_in = rd_data_ff.parent;
      end
   end

   // Walk and root registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.load_edge) begin
         vb_ff <= VW'(req_vertex_b);
      end
      if (cmd.chk_a && status.is_root) begin
         root_a_ff <= cur_ff;
         size_a_ff <= rd_data_ff.size;
      end
      if (cmd.chk_b && status.is_root) begin
         root_b_ff <= cur_ff;
         size_b_ff <= rd_data_ff.size;
      end
   end

   // Control registers: count, sweep pointer, running maximum, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= '0;
         clr_idx_ff   <= '0;
         largest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
         if (cmd.emit) begin
            clr_idx_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_idx_ff <= clr_idx_ff + VW'(1);
         end
         if (cmd.emit) begin
            largest_ff <= '0;
         end else if (cmd.link_big && (merged > largest_ff)) begin
            largest_ff <= merged;
         end
         rsp_valid_ff <= cmd.emit || (rsp_valid_ff && !rsp_ready);
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_largest_size_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_largest_size = rsp_largest_size_ff;

endmodule

// ===== rtl/largest_component_size_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_component_size_top: largest connected component of a graph
// Union-find over a table of MAX_VERTICES entries, merged one edge at a time.
// ----------------------------------------------------------------------------
// An edge request (req_cmd 0) whose endpoints are both below the vertex count
// walks from each endpoint to its root, with one table read and one check per
// entry visited, then compares the roots and, if they differ, links the smaller
// root under the larger and then writes the merged size at the larger root.
// Union by size keeps depths at most log2 of the component size. An edge out of
// range is taken and dropped. A finish request (req_cmd 1) posts the result and
// then clears the table in a sweep over all MAX_VERTICES entries, one entry per
// cycle, during which req_ready is low; the same sweep runs after reset. The
// vertex count register may be written at any time; it is applied to each
// request as it arrives.
// ----------------------------------------------------------------------------
module largest_component_size_top #(
   parameter int MAX_VERTICES = lcs_pkg::MAX_VERTICES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [lcs_pkg::VERTEX_W-1:0]  req_vertex_a,
   input  logic [lcs_pkg::VERTEX_W-1:0]  req_vertex_b,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lcs_pkg::SIZE_W-1:0]    rsp_largest_size,
   input  logic                          csr_wr_en,
   input  logic [lcs_pkg::COUNT_W-1:0]   csr_wr_data
);
   import lcs_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Sequencer
   lcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Table and registers
   lcs_dpath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_vertex_a     (req_vertex_a),
      .req_vertex_b     (req_vertex_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_largest_size (rsp_largest_size),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== tb/sv/largest_component_size_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_component_size_top_tb: self-checking bench for the component sizer
// Drives edge and finish requests under random flow control on both sides,
// tracks the graph in a union-find predictor of its own and checks each
// reported largest component size, in order, against the predicted or fixed value.
// ----------------------------------------------------------------------------
module largest_component_size_top_tb;

   import lcs_pkg::*;

   localparam int TABLE_DEPTH  = MAX_VERTICES_DEF;
   // table sweep after a finish plus the longest edge walk, with margin
   localparam int SETTLE_CYCLES = TABLE_DEPTH + 64;
   localparam int STALL_LIMIT   = 12000;
   localparam int ITEM_TARGET   = 2000;
   localparam int MAX_GAP       = 18;

   typedef enum logic {
      CMD_EDGE   = 1'b0,
      CMD_FINISH = 1'b1
   } graph_cmd_type;

   // one directed row: optional count write, the request, optional fixed answer
   typedef struct packed {
      logic                set_count;
      logic [COUNT_W-1:0]  count;
      graph_cmd_type       cmd;
      logic [VERTEX_W-1:0] va;
      logic [VERTEX_W-1:0] vb;
      logic                typed;
      logic [SIZE_W-1:0]   want;
   } probe_row_type;

   localparam int NUM_PROBES = 24;
   localparam probe_row_type PROBES [0:NUM_PROBES-1] = '{
      // empty graph, edges with no vertices, finish with nonzero endpoints
      '{1'b1, 11'd0,    CMD_FINISH, 10'd0,    10'd0,    1'b1, 11'd0},
      '{1'b0, 11'd0,    CMD_EDGE,   10'd0,    10'd0,    1'b0, 11'd0},
      '{1'b0, 11'd0,    CMD_FINISH, 10'd1023, 10'd1023, 1'b1, 11'd0},
      // single vertex, self loop
      '{1'b1, 11'd1,    CMD_FINISH, 10'd0,    10'd0,    1'b1, 11'd1},
      '{1'b0, 11'd0,    CMD_EDGE,   10'd0,    10'd0,    1'b0, 11'd0},
      '{1'b0, 11'd0,    CMD_FINISH, 10'd0,    10'd0,    1'b1, 11'd1},
      // full table, repeated edge, two pairs joined
      '{1'b1, 11'd1024, CMD_EDGE,   10'd0,    10'd1023, 1'b0, 11'd0},
      '{1'b0, 11'd0,    CMD_EDGE,   10'd1023, 10'd0,    1'b0, 11'd0},
      '{1'b0, 11'd0,    CMD_EDGE,   10'd1,    10'd2,    1'b0, 11'd0},
      '{1'b0, 11'd0,    CMD_EDGE,   10'd2,    10'd0,    1'b0, 11'd0},
      '{1'b0, 11'd0,    CMD_FINISH, 10'd0,    10'd0,    1'b1, 11'd4},
      // count above the table depth acts as the table depth
      '{1'b1, 11'd2047, CMD_EDGE,   10'd1023, 10'd1022, 1'b0, 11'd0},
      '{1'b0, 11'd0,    CMD_FINISH, 10'd0,    10'd0,    1'b1, 11'd2},
      // endpoints out of range, then count cleared before the finish
      '{1'b1, 11'd3,    CMD_EDGE,   10'd0,    10'd5,    1'b0, 11'd0},
      '{1'b0, 11'd0,    CMD_EDGE,   10'd5,    10'd0,    1'b0, 11'd0},
      '{1'b0, 11'd0,    CMD_EDGE,   10'd2,    10'd1,    1'b0, 11'd0},
      '{1'b1, 11'd0,    CMD_FINISH, 10'd0,    10'd0,    1'b1, 11'd0},
      // count lowered mid-graph: earlier merge stays counted
      '{1'b1, 11'd10,   CMD_EDGE,   10'd5,    10'd6,    1'b0, 11'd0},
      '{1'b1, 11'd2,    CMD_EDGE,   10'd5,    10'd7,    1'b0, 11'd0},
      '{1'b0, 11'd0,    CMD_FINISH, 10'd0,    10'd0,    1'b1, 11'd2},
      // alternating bit patterns on the endpoints
      '{1'b1, 11'd1024, CMD_EDGE,   10'd512,  10'd511,  1'b0, 11'd0},
      '{1'b0, 11'd0,    CMD_EDGE,   10'd1023, 10'd1023, 1'b0, 11'd0},
      '{1'b0, 11'd0,    CMD_EDGE,   10'd341,  10'd682,  1'b0, 11'd0},
      '{1'b0, 11'd0,    CMD_FINISH, 10'd0,    10'd0,    1'b0, 11'd0}
   };

   logic                clock;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_ready;
   logic                req_cmd      = 1'b0;
   logic [VERTEX_W-1:0] req_vertex_a = '0;
   logic [VERTEX_W-1:0] req_vertex_b = '0;
   logic                rsp_valid;
   logic                rsp_ready    = 1'b0;
   logic [SIZE_W-1:0]   rsp_largest_size;
   logic                csr_wr_en    = 1'b0;
   logic [COUNT_W-1:0]  csr_wr_data  = '0;

   // predictor copy of the graph and the count register
   logic [VERTEX_W-1:0] uf_parent [TABLE_DEPTH];
   logic [SIZE_W-1:0]   uf_size   [TABLE_DEPTH];
   logic [SIZE_W-1:0]   uf_best;
   logic [COUNT_W-1:0]  vertex_count_q;

   logic [SIZE_W-1:0]   expected_sizes [$];
   int                  mismatch_count = 0;
   int                  quiet_cycles   = 0;
   bit                  sender_calm    = 1'b0;
   bit                  receiver_calm  = 1'b0;

   largest_component_size_top #(
      .MAX_VERTICES (TABLE_DEPTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_vertex_a     (req_vertex_a),
      .req_vertex_b     (req_vertex_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_largest_size (rsp_largest_size),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic void clear_graph();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         uf_parent[i] = VERTEX_W'(i);
         uf_size[i]   = SIZE_W'(1);
      end
      uf_best = '0;
   endfunction

   function automatic int live_vertices();
      return (int'(vertex_count_q) > TABLE_DEPTH) ? TABLE_DEPTH : int'(vertex_count_q);
   endfunction

   function automatic logic [VERTEX_W-1:0] root_of(input logic [VERTEX_W-1:0] v);
      int s;
      for (s = 0; s < TABLE_DEPTH; s++) begin
         if (uf_parent[v] == v) break;
         v = uf_parent[v];
      end
      return v;
   endfunction

   // Apply one request to the graph; returns 1 with the size when it reports
   function automatic bit apply_graph_request(input graph_cmd_type cmd,
                                              input logic [VERTEX_W-1:0] va,
                                              input logic [VERTEX_W-1:0] vb,
                                              output logic [SIZE_W-1:0] size);
      int                  n;
      logic [VERTEX_W-1:0] ra, rb, big, sml;
      logic [SIZE_W-1:0]   merged;
      n    = live_vertices();
      size = '0;
      if (cmd == CMD_FINISH) begin
         if (n != 0) size = (uf_best > 1) ? uf_best : SIZE_W'(1);
         clear_graph();
         return 1'b1;
      end
      if (int'(va) < n && int'(vb) < n) begin
         ra = root_of(va);
         rb = root_of(vb);
         if (ra != rb) begin
            // larger component absorbs the smaller one
            big = ra;
            sml = rb;
            if (uf_size[ra] < uf_size[rb]) begin
               big = rb;
               sml = ra;
            end
            merged         = uf_size[big] + uf_size[sml];
            uf_parent[sml] = big;
            uf_size[big]   = merged;
            if (merged > uf_best) uf_best = merged;
         end
      end
      return 1'b0;
   endfunction

   // Present one request after a random gap and hold it until taken
   task automatic send_request(input graph_cmd_type cmd, input logic [VERTEX_W-1:0] va,
                               input logic [VERTEX_W-1:0] vb);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_vertex_a <= va;
      req_vertex_b <= vb;
      do @(posedge clock); while (!req_ready);
   endtask

   // Send a request and queue the size it must report, if any
   task automatic post_request(input graph_cmd_type cmd, input logic [VERTEX_W-1:0] va,
                               input logic [VERTEX_W-1:0] vb, input logic typed,
                               input logic [SIZE_W-1:0] want);
      logic [SIZE_W-1:0] size;
      send_request(cmd, va, vb);
      if (apply_graph_request(cmd, va, vb, size))
         expected_sizes.push_back(typed ? want : size);
   endtask

   // Count write: drain all results, let the block settle, then write
   task automatic write_count(input logic [COUNT_W-1:0] value);
      req_valid <= 1'b0;
      while (expected_sizes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      vertex_count_q  = value;
   endtask

   // Result side: random stall per result, then check against the queue
   initial begin
      int stall;
      forever begin
         stall = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (expected_sizes.size() == 0) begin
            report_mismatch("unexpected rsp_largest_size", int'(rsp_largest_size), 0);
         end else begin
            if (rsp_largest_size !== expected_sizes[0])
               report_mismatch("rsp_largest_size", int'(rsp_largest_size),
                               int'(expected_sizes[0]));
            void'(expected_sizes.pop_front());
         end
      end
   end

   // Watchdog: ends the run when no request or result moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("largest_component_size_top: mismatch");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      int                  counted;
      int                  n;
      int                  edges;
      int                  base;
      int                  span;
      logic [COUNT_W-1:0]  pick;
      logic [VERTEX_W-1:0] va, vb;

      clear_graph();
      vertex_count_q = '0;
      counted        = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      for (int r = 0; r < NUM_PROBES; r++) begin
         if (PROBES[r].set_count) write_count(PROBES[r].count);
         post_request(PROBES[r].cmd, PROBES[r].va, PROBES[r].vb,
                      PROBES[r].typed, PROBES[r].want);
      end

      // one graph spanning the whole table: largest size reaches its top
      write_count(COUNT_W'(TABLE_DEPTH));
      for (int i = 1; i < TABLE_DEPTH; i++)
         post_request(CMD_EDGE, VERTEX_W'(i), VERTEX_W'($urandom_range(0, i - 1)), 1'b0, '0);
      post_request(CMD_FINISH, VERTEX_W'($urandom), VERTEX_W'($urandom), 1'b0, '0);
      counted += TABLE_DEPTH;

      // random graphs, mostly small so components grow large
      while (counted < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            6:       pick = COUNT_W'(TABLE_DEPTH);
            7:       pick = COUNT_W'($urandom_range(0, 2047));
            8:       pick = COUNT_W'($urandom_range(41, 300));
            9:       pick = COUNT_W'($urandom_range(0, 2));
            default: pick = COUNT_W'($urandom_range(2, 40));
         endcase
         sender_calm   = ($urandom_range(0, 4) == 0);
         receiver_calm = ($urandom_range(0, 4) == 0);
         write_count(pick);
         repeat ($urandom_range(1, 3)) begin
            n     = live_vertices();
            span  = (n > 48) ? 48 : n;
            edges = (n == 0) ? $urandom_range(0, 4) : $urandom_range(0, 2 * span);
            repeat (edges) begin
               // occasional count change in the middle of a graph
               if ($urandom_range(0, 59) == 0) write_count(COUNT_W'($urandom_range(0, 2047)));
               n    = live_vertices();
               span = (n > 48) ? 48 : n;
               if (n == 0 || $urandom_range(0, 7) == 0) begin
                  va = VERTEX_W'($urandom);
                  vb = VERTEX_W'($urandom);
               end else begin
                  base = $urandom_range(0, n - span);
                  va   = VERTEX_W'(base + $urandom_range(0, span - 1));
                  vb   = VERTEX_W'(base + $urandom_range(0, span - 1));
               end
               counted++;
               post_request(CMD_EDGE, va, vb, 1'b0, '0);
            end
            post_request(CMD_FINISH, VERTEX_W'($urandom), VERTEX_W'($urandom), 1'b0, '0);
            counted++;
         end
      end

      // drain and let the final clearing sweep finish
      req_valid <= 1'b0;
      while (expected_sizes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("largest_component_size_top: match");
      else
         $display("largest_component_size_top: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lcs_pkg.sv
rtl/lcs_ctrl.sv
rtl/lcs_dpath.sv
rtl/largest_component_size_top.sv
tb/sv/largest_component_size_top_tb.sv
